// ----- hdl/dqpc_pkg.sv -----
// Shared types, constants and helpers of the DNS query packet classifier.
package dqpc_pkg;

  // Default limit on non-zero query-name bytes
  localparam int unsigned MAX_NAME_BYTES_DEF = 256;

  // Entries in the queue between parser and output stage
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [15:0] DNS_PORT_RST = 16'd53;
  localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6   = 16'h86DD;
  localparam logic [7:0]  IP_PROTO_UDP = 8'd17;

  // Fixed byte offsets inside the headers
  localparam logic [5:0] OFF_ETYPE_HI = 6'd12;
  localparam logic [5:0] OFF_ETYPE_LO = 6'd13;
  localparam logic [5:0] OFF_IP4_VIHL = 6'd0;
  localparam logic [5:0] OFF_IP4_PROT = 6'd9;
  localparam logic [5:0] OFF_IP4_LAST = 6'd19;
  localparam logic [5:0] OFF_IP6_NXT  = 6'd6;
  localparam logic [5:0] OFF_IP6_LAST = 6'd39;
  localparam logic [5:0] OFF_UDP_DP0  = 6'd2;
  localparam logic [5:0] OFF_UDP_DP1  = 6'd3;
  localparam logic [5:0] OFF_UDP_LN1  = 6'd5;
  localparam logic [5:0] OFF_UDP_LAST = 6'd7;
  localparam logic [5:0] OFF_DNS_FLG  = 6'd2;
  localparam logic [5:0] OFF_DNS_LAST = 6'd11;
  localparam logic [5:0] OFF_MAX      = 6'h3F;

  localparam logic [3:0]  IHL_MIN     = 4'd5;
  localparam logic [15:0] UDP_LEN_MIN = 16'd8;
  localparam logic [2:0]  TAIL_FULL   = 3'd4;

  typedef enum logic [2:0] {
    PH_ETH  = 3'd0,
    PH_IP4  = 3'd1,
    PH_IP6  = 3'd2,
    PH_UDP  = 3'd3,
    PH_DNS  = 3'd4,
    PH_NAME = 3'd5,
    PH_TAIL = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    V_DROP  = 2'd0,
    V_PASS  = 2'd1,
    V_QUERY = 2'd2
  } verdict_e;

  typedef enum logic {
    KIND_NAME    = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e       item_kind;
    logic [7:0]  name_byte;
    verdict_e    verdict;
    logic [8:0]  key_len;
    logic [8:0]  query_len;
  } result_t;

  function automatic result_t make_verdict(verdict_e v, logic [8:0] k, logic [8:0] q);
    result_t r;
    r.item_kind = KIND_VERDICT;
    r.name_byte = 8'd0;
    r.verdict   = v;
    r.key_len   = k;
    r.query_len = q;
    return r;
  endfunction

  function automatic result_t make_name(logic [7:0] b);
    result_t r;
    r.item_kind = KIND_NAME;
    r.name_byte = b;
    r.verdict   = V_DROP;
    r.key_len   = 9'd0;
    r.query_len = 9'd0;
    return r;
  endfunction

endpackage

// ----- hdl/dqpc_if.sv -----
// Valid/ready channel interfaces for frame bytes and classifier results.
interface dqpc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] pkt_byte;
  logic       frame_last;

  modport source (output valid, output pkt_byte, output frame_last, input ready);
  modport sink   (input valid, input pkt_byte, input frame_last, output ready);
endinterface

interface dqpc_res_if;
  logic       valid;
  logic       ready;
  logic       item_kind;
  logic [7:0] name_byte;
  logic [1:0] verdict;
  logic [8:0] key_len;
  logic [8:0] query_len;

  modport source (output valid, output item_kind, output name_byte, output verdict,
                  output key_len, output query_len, input ready);
  modport sink   (input valid, input item_kind, input name_byte, input verdict,
                  input key_len, input query_len, output ready);
endinterface

// ----- hdl/dqpc_parser.sv -----
// Front end: header parser that classifies each frame byte and queues results.
module dqpc_parser import dqpc_pkg::*; #(
  parameter int unsigned MAX_NAME_BYTES = MAX_NAME_BYTES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          dns_port_we_i,
  input  logic [15:0]   dns_port_i,
  dqpc_byte_if.sink     pkt_i,
  input  logic          full_i,
  output logic          push_o,
  output result_t       push_data_o
);

  localparam int unsigned CW = $clog2(MAX_NAME_BYTES);
  localparam int unsigned KW = (CW + 1 > 9) ? CW + 1 : 9;

  logic [15:0] dns_port_q;
  phase_e      phase_q, phase_d;
  logic [5:0]  off_q, off_d;
  logic [5:0]  l4_q, l4_d;
  logic [15:0] shift_q, shift_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [2:0]  tail_q, tail_d;
  logic        sent_q, sent_d;

  logic        fire;
  logic [7:0]  b;
  logic        last;
  logic [15:0] sh;
  logic [5:0]  l4;
  logic [2:0]  tinc;
  logic        adv;
  logic        emit;
  result_t     res;
  logic [KW-1:0] key_w, qlen_w;

  assign pkt_i.ready = ~full_i;
  assign fire        = pkt_i.valid & pkt_i.ready;
  assign b           = pkt_i.pkt_byte;
  assign last        = pkt_i.frame_last;

  assign key_w  = KW'(cnt_q) + KW'(1);
  assign qlen_w = KW'(cnt_q) + KW'(5);

  // Per-byte parse step
  always_comb begin
    phase_d = phase_q;
    off_d   = off_q;
    l4_d    = l4_q;
    shift_d = shift_q;
    cnt_d   = cnt_q;
    tail_d  = tail_q;
    sent_d  = sent_q;
    sh      = shift_q;
    l4      = l4_q;
    tinc    = tail_q + 3'd1;
    adv     = 1'b1;
    emit    = 1'b0;
    res     = make_name(b);

    if (fire) begin
      if (!sent_q) begin
        unique case (phase_q)
          PH_ETH: begin
            if (off_q == OFF_ETYPE_HI || off_q == OFF_ETYPE_LO) begin
              sh      = {shift_q[7:0], b};
              shift_d = sh;
            end
            if (off_q == OFF_ETYPE_LO) begin
              adv = 1'b0;
              if (sh == ETYPE_IPV4) begin
                phase_d = PH_IP4; off_d = '0; shift_d = '0; tail_d = '0;
              end else if (sh == ETYPE_IPV6) begin
                phase_d = PH_IP6; off_d = '0; shift_d = '0; tail_d = '0;
              end else begin
                emit = 1'b1; res = make_verdict(V_PASS, 9'd0, 9'd0);
              end
            end
          end
          PH_IP4: begin
            if (off_q == OFF_IP4_VIHL && b[3:0] < IHL_MIN) begin
              emit = 1'b1; res = make_verdict(V_DROP, 9'd0, 9'd0);
            end else begin
              if (off_q == OFF_IP4_VIHL) begin
                l4   = {b[3:0], 2'b00};
                l4_d = l4;
              end
              if (off_q == OFF_IP4_PROT) begin
                sh      = {8'd0, b};
                shift_d = sh;
              end
              if (off_q == OFF_IP4_LAST && sh[7:0] != IP_PROTO_UDP) begin
                emit = 1'b1; res = make_verdict(V_PASS, 9'd0, 9'd0);
              end else if (off_q >= OFF_IP4_LAST && ({1'b0, off_q} + 7'd1) >= {1'b0, l4}) begin
                adv = 1'b0;
                phase_d = PH_UDP; off_d = '0; shift_d = '0; tail_d = '0;
              end
            end
          end
          PH_IP6: begin
            if (off_q == OFF_IP6_NXT) begin
              sh      = {8'd0, b};
              shift_d = sh;
            end
            if (off_q == OFF_IP6_LAST) begin
              adv = 1'b0;
              if (sh[7:0] != IP_PROTO_UDP) begin
                emit = 1'b1; res = make_verdict(V_PASS, 9'd0, 9'd0);
              end else begin
                phase_d = PH_UDP; off_d = '0; shift_d = '0; tail_d = '0;
              end
            end
          end
          PH_UDP: begin
            // destination port at 2..3, length at 4..5; tail flags a port mismatch
            if (off_q >= OFF_UDP_DP0 && off_q <= OFF_UDP_LN1) begin
              sh      = {shift_q[7:0], b};
              shift_d = sh;
            end
            if (off_q == OFF_UDP_DP1) begin
              tail_d  = {2'b00, sh != dns_port_q};
              shift_d = '0;
            end
            if (off_q == OFF_UDP_LAST) begin
              adv = 1'b0;
              if (shift_q < UDP_LEN_MIN) begin
                emit = 1'b1; res = make_verdict(V_DROP, 9'd0, 9'd0);
              end else if (tail_q != 3'd0) begin
                emit = 1'b1; res = make_verdict(V_PASS, 9'd0, 9'd0);
              end else begin
                phase_d = PH_DNS; off_d = '0; shift_d = '0; tail_d = '0;
              end
            end
          end
          PH_DNS: begin
            // QR and opcode live in the top five bits of the flags byte
            if (off_q == OFF_DNS_FLG) tail_d = {2'b00, |b[7:3]};
            if (off_q == OFF_DNS_LAST) begin
              adv = 1'b0;
              if (tail_q != 3'd0) begin
                emit = 1'b1; res = make_verdict(V_PASS, 9'd0, 9'd0);
              end else begin
                phase_d = PH_NAME; off_d = '0; shift_d = '0; tail_d = '0;
                cnt_d   = '0;
              end
            end
          end
          PH_NAME: begin
            adv = 1'b0;
            if (b != 8'd0) begin
              if (cnt_q >= CW'(MAX_NAME_BYTES - 1) || last) begin
                emit = 1'b1; res = make_verdict(V_DROP, 9'd0, 9'd0);
              end else begin
                emit  = 1'b1; res = make_name(b);
                cnt_d = cnt_q + CW'(1);
              end
            end else if (last) begin
              emit = 1'b1; res = make_verdict(V_QUERY, 9'd0, qlen_w[8:0]);
            end else begin
              phase_d = PH_TAIL; off_d = '0; shift_d = '0; tail_d = '0;
            end
          end
          PH_TAIL: begin
            adv    = 1'b0;
            tail_d = tinc;
            if (tinc >= TAIL_FULL) begin
              emit = 1'b1; res = make_verdict(V_QUERY, key_w[8:0], qlen_w[8:0]);
            end else if (last) begin
              emit = 1'b1; res = make_verdict(V_QUERY, 9'd0, qlen_w[8:0]);
            end
          end
          default: begin
            adv = 1'b0;
          end
        endcase

        if (emit && res.item_kind == KIND_VERDICT) sent_d = 1'b1;
        if (adv && !sent_d && off_q != OFF_MAX) off_d = off_q + 6'd1;
        // frame ends before any verdict
        if (last && !sent_d) begin
          emit = 1'b1; res = make_verdict(V_DROP, 9'd0, 9'd0);
        end
      end

      // next byte starts a new frame
      if (last) begin
        phase_d = PH_ETH;
        off_d   = '0;
        l4_d    = '0;
        shift_d = '0;
        cnt_d   = '0;
        tail_d  = '0;
        sent_d  = 1'b0;
      end
    end
  end

  assign push_o      = fire & emit;
  assign push_data_o = res;

  // Parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ETH;
      off_q   <= '0;
      l4_q    <= '0;
      shift_q <= '0;
      cnt_q   <= '0;
      tail_q  <= '0;
      sent_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      off_q   <= off_d;
      l4_q    <= l4_d;
      shift_q <= shift_d;
      cnt_q   <= cnt_d;
      tail_q  <= tail_d;
      sent_q  <= sent_d;
    end
  end

  // Port register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dns_port_q <= DNS_PORT_RST;
    end else if (dns_port_we_i) begin
      dns_port_q <= dns_port_i;
    end
  end

  // Only one verdict per frame
  a_one_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && push_data_o.item_kind == KIND_VERDICT |-> !sent_q)
    else $error("second verdict in one frame");

  // A verdict on a non-final byte mutes the rest of the frame
  a_mute_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && push_data_o.item_kind == KIND_VERDICT && !pkt_i.frame_last |=> sent_q)
    else $error("verdict not recorded");

  // The last byte of a frame always carries a verdict unless one was given
  a_last_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && pkt_i.frame_last && !sent_q |->
      push_o && push_data_o.item_kind == KIND_VERDICT)
    else $error("frame closed without verdict");

endmodule

// ----- hdl/dqpc_fifo.sv -----
// Short result queue between the parser and the output stage.
module dqpc_fifo import dqpc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t data_i,
  output logic    full_o,
  input  logic    pop_i,
  output result_t data_o,
  output logic    empty_o
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);

  result_t     mem_q [QUEUE_DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0] cnt_q;

  assign full_o  = (cnt_q == (AW+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  // Storage, no reset on payload
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + AW'(1);
      if (pop_i)  rd_q <= (rd_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + AW'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + (AW+1)'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - (AW+1)'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from empty queue");

endmodule

// ----- hdl/dqpc_out.sv -----
// Back end: output register that drains the queue onto the result channel.
module dqpc_out import dqpc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  result_t    data_i,
  input  logic       empty_i,
  output logic       pop_o,
  dqpc_res_if.source res_o
);

  result_t res_q;
  logic    vld_q;

  // Load when the register is free or being taken this cycle
  assign pop_o = ~empty_i & (~vld_q | res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (pop_o) begin
      vld_q <= 1'b1;
    end else if (res_o.ready) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) res_q <= data_i;
  end

  assign res_o.valid     = vld_q;
  assign res_o.item_kind = res_q.item_kind;
  assign res_o.name_byte = res_q.name_byte;
  assign res_o.verdict   = res_q.verdict;
  assign res_o.key_len   = res_q.key_len;
  assign res_o.query_len = res_q.query_len;

endmodule

// ----- hdl/dns_query_packet_classifier.sv -----
// Top level of the DNS query packet classifier.
// Takes one frame byte per clock while the queue has room and emits the non-zero query-name bytes
// followed by exactly one verdict per frame (drop, pass or query with key and question lengths).
// The parser handles one byte per cycle in a single stage, so sustained throughput is one byte per
// clock until the queue fills; a result is written into the queue and then into the output
// register. A four-entry queue sits between parser and output register, so the byte input keeps
// flowing while up to five results wait for the consumer; once the queue is full the input stalls.
// dns_port resets to 53; the user must write it only while the block is idle (not enforced here).
module dns_query_packet_classifier import dqpc_pkg::*; #(
  parameter int unsigned MAX_NAME_BYTES = MAX_NAME_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        dns_port_we_i,
  input  logic [15:0] dns_port_i,
  dqpc_byte_if.sink   pkt_i,
  dqpc_res_if.source  res_o
);

  logic    push, pop, full, empty;
  result_t push_data, head_data;

  dqpc_parser #(
    .MAX_NAME_BYTES (MAX_NAME_BYTES)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .dns_port_we_i (dns_port_we_i),
    .dns_port_i    (dns_port_i),
    .pkt_i         (pkt_i),
    .full_i        (full),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  dqpc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (head_data),
    .empty_o (empty)
  );

  dqpc_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .data_i  (head_data),
    .empty_i (empty),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule

// ----- dv/tb_dns_query_packet_classifier.sv -----
// Self-checking testbench for the DNS query packet classifier.
`timescale 1ns / 100ps

module tb_dns_query_packet_classifier;
  import dqpc_pkg::*;

  localparam int unsigned NAME_LIMIT     = MAX_NAME_BYTES_DEF;
  localparam logic [15:0] DNS_PORT_RESET = 16'd53;
  localparam logic [15:0] ETYPE_ARP      = 16'h0806;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_ICMP6    = 8'd58;
  localparam int          IDLE_PCT       = 37;
  localparam int          SETTLE_CYCLES  = 8;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          FRAMES_PER_SET = 80;
  localparam int          MAX_REPORTS    = 30;

  typedef logic [7:0] byte_q_t[$];

  // One frame as the stimulus sees it; want_* hold a verdict typed in by hand
  typedef struct {
    logic [15:0] etype;
    logic [7:0]  vihl;
    logic [7:0]  proto;
    logic [15:0] dport;
    logic [15:0] ulen;
    logic [7:0]  dflags;
    int          name_n;
    bit          name_end;
    int          tail_n;
    int          cut;
    bit          typed;
    verdict_e    want;
    logic [8:0]  want_key;
    logic [8:0]  want_qlen;
  } frame_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        dns_port_we;
  logic [15:0] dns_port;

  dqpc_byte_if frame_ch ();
  dqpc_res_if  result_ch ();

  dns_query_packet_classifier #(
    .MAX_NAME_BYTES(NAME_LIMIT)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .dns_port_we_i(dns_port_we),
    .dns_port_i   (dns_port),
    .pkt_i        (frame_ch),
    .res_o        (result_ch)
  );

  always #5 clk = ~clk;

  // Parser state mirrored by the predictor
  phase_e      ph;
  logic [15:0] hdr_off;
  logic [7:0]  ip_hlen;
  logic [15:0] fld;
  logic [8:0]  name_cnt;
  logic [2:0]  tail_cnt;
  bit          done;
  logic [15:0] port_cfg;

  result_t pending_items[$];
  int      mismatches = 0;
  bit      steady = 1'b0;
  int      stall_cycles = 0;

  function automatic void start_frame();
    ph       = PH_ETH;
    hdr_off  = '0;
    ip_hlen  = '0;
    fld      = '0;
    name_cnt = '0;
    tail_cnt = '0;
    done     = 1'b0;
  endfunction

  function automatic void enter_phase(phase_e p);
    ph       = p;
    hdr_off  = '0;
    fld      = '0;
    tail_cnt = '0;
  endfunction

  function automatic result_t close_frame(verdict_e v, logic [8:0] k, logic [8:0] q);
    result_t r;
    r.item_kind = KIND_VERDICT;
    r.name_byte = 8'd0;
    r.verdict   = v;
    r.key_len   = k;
    r.query_len = q;
    done = 1'b1;
    return r;
  endfunction

  // Predict the result, if any, that one accepted frame byte produces
  function automatic bit classify_byte(input logic [7:0] b, input bit is_last,
                                       output result_t r);
    logic [15:0] off;
    bit          adv;
    bit          name_out;
    bit          was_done;
    off      = hdr_off;
    adv      = 1'b1;
    name_out = 1'b0;
    was_done = done;
    r        = '0;
    if (!done) begin
      case (ph)
        PH_ETH: begin
          if (off == 12 || off == 13) fld = {fld[7:0], b};
          if (off == 13) begin
            adv = 1'b0;
            if (fld == ETYPE_IPV4) enter_phase(PH_IP4);
            else if (fld == ETYPE_IPV6) enter_phase(PH_IP6);
            else r = close_frame(V_PASS, 9'd0, 9'd0);
          end
        end
        PH_IP4: begin
          // short IHL is dropped on the first header byte
          if (off == 0 && b[3:0] < 4'd5) begin
            r = close_frame(V_DROP, 9'd0, 9'd0);
          end else begin
            if (off == 0) ip_hlen = {2'b00, b[3:0], 2'b00};
            if (off == 9) fld = {8'h00, b};
            if (off == 19 && fld != {8'h00, IP_PROTO_UDP}) begin
              r = close_frame(V_PASS, 9'd0, 9'd0);
            end else if (off >= 19 && off + 1 >= ip_hlen) begin
              adv = 1'b0;
              enter_phase(PH_UDP);
            end
          end
        end
        PH_IP6: begin
          if (off == 6) fld = {8'h00, b};
          if (off == 39) begin
            adv = 1'b0;
            if (fld != {8'h00, IP_PROTO_UDP}) r = close_frame(V_PASS, 9'd0, 9'd0);
            else enter_phase(PH_UDP);
          end
        end
        PH_UDP: begin
          if (off >= 2 && off <= 5) fld = {fld[7:0], b};
          if (off == 3) begin
            tail_cnt = 3'(fld != port_cfg);
            fld      = '0;
          end
          // length is checked before the port
          if (off == 7) begin
            adv = 1'b0;
            if (fld < 16'd8) r = close_frame(V_DROP, 9'd0, 9'd0);
            else if (tail_cnt != 0) r = close_frame(V_PASS, 9'd0, 9'd0);
            else enter_phase(PH_DNS);
          end
        end
        PH_DNS: begin
          if (off == 2) tail_cnt = 3'((b & 8'hF8) != 8'h00);
          if (off == 11) begin
            adv = 1'b0;
            if (tail_cnt != 0) begin
              r = close_frame(V_PASS, 9'd0, 9'd0);
            end else begin
              enter_phase(PH_NAME);
              name_cnt = '0;
            end
          end
        end
        PH_NAME: begin
          adv = 1'b0;
          if (b != 8'h00) begin
            if (name_cnt + 1 >= NAME_LIMIT || is_last) begin
              r = close_frame(V_DROP, 9'd0, 9'd0);
            end else begin
              r.item_kind = KIND_NAME;
              r.name_byte = b;
              r.verdict   = V_DROP;
              name_out    = 1'b1;
              name_cnt++;
            end
          end else if (is_last) begin
            r = close_frame(V_QUERY, 9'd0, name_cnt + 9'd5);
          end else begin
            enter_phase(PH_TAIL);
          end
        end
        default: begin
          adv      = 1'b0;
          tail_cnt = tail_cnt + 3'd1;
          if (tail_cnt >= 3'd4) r = close_frame(V_QUERY, name_cnt + 9'd1, name_cnt + 9'd5);
          else if (is_last) r = close_frame(V_QUERY, 9'd0, name_cnt + 9'd5);
        end
      endcase
      if (adv && !done && hdr_off < 16'hFFFF) hdr_off++;
      if (is_last && !done) r = close_frame(V_DROP, 9'd0, 9'd0);
    end
    classify_byte = name_out || (done && !was_done);
    if (is_last) start_frame();
  endfunction

  // Lay out the bytes of a frame from its descriptor
  function automatic void build_frame(input frame_t f, output byte_q_t q);
    int hl;
    q = {};
    repeat (12) q.push_back(8'($urandom));
    q.push_back(f.etype[15:8]);
    q.push_back(f.etype[7:0]);
    if (f.etype == ETYPE_IPV4) begin
      hl = (f.vihl[3:0] < 4'd5) ? 20 : 4 * f.vihl[3:0];
      q.push_back(f.vihl);
      for (int i = 1; i < hl; i++) q.push_back(i == 9 ? f.proto : 8'($urandom));
    end else if (f.etype == ETYPE_IPV6) begin
      for (int i = 0; i < 40; i++) q.push_back(i == 6 ? f.proto : 8'($urandom));
    end
    // UDP header
    q.push_back(8'($urandom));
    q.push_back(8'($urandom));
    q.push_back(f.dport[15:8]);
    q.push_back(f.dport[7:0]);
    q.push_back(f.ulen[15:8]);
    q.push_back(f.ulen[7:0]);
    q.push_back(8'($urandom));
    q.push_back(8'($urandom));
    // DNS header, flags in byte 2
    for (int i = 0; i < 12; i++) q.push_back(i == 2 ? f.dflags : 8'($urandom));
    repeat (f.name_n) q.push_back(8'($urandom_range(1, 255)));
    if (f.name_end) q.push_back(8'h00);
    repeat (f.tail_n) q.push_back(8'($urandom));
    if (f.cut > 0 && f.cut < q.size()) q = q[0:f.cut-1];
  endfunction

  // Mostly well-formed queries for the current port, the rest corrupted
  function automatic frame_t random_frame();
    frame_t f;
    f.etype     = $urandom_range(1) ? ETYPE_IPV4 : ETYPE_IPV6;
    f.vihl      = {4'h4, 4'($urandom_range(5, 6))};
    if ($urandom_range(9) == 0) f.vihl[3:0] = 4'($urandom_range(7, 15));
    f.proto     = IP_PROTO_UDP;
    f.dport     = port_cfg;
    f.ulen      = 16'($urandom_range(8, 65535));
    f.dflags    = {5'b00000, 3'($urandom)};
    f.name_n    = $urandom_range(0, 24);
    if ($urandom_range(99) < 4) f.name_n = $urandom_range(240, 300);
    f.name_end  = $urandom_range(9) != 0;
    f.tail_n    = $urandom_range(0, 8);
    f.cut       = 0;
    f.typed     = 1'b0;
    f.want      = V_DROP;
    f.want_key  = '0;
    f.want_qlen = '0;
    if ($urandom_range(99) < 30) begin
      case ($urandom_range(7))
        0: f.etype  = 16'($urandom);
        1: f.vihl   = 8'($urandom);
        2: f.proto  = 8'($urandom);
        3: f.dport  = 16'($urandom);
        4: f.ulen   = 16'($urandom_range(0, 15));
        5: f.dflags = 8'($urandom);
        6: f.cut    = $urandom_range(1, 80);
        default: begin
          f.etype  = $urandom_range(3) == 0 ? 16'($urandom) : f.etype;
          f.vihl   = 8'($urandom);
          f.proto  = 8'($urandom);
          f.dport  = 16'($urandom);
          f.ulen   = 16'($urandom);
          f.dflags = 8'($urandom);
          f.cut    = $urandom_range(0, 90);
        end
      endcase
    end
    return f;
  endfunction

  // Present one byte and wait for its transfer
  task automatic put_byte(input logic [7:0] b, input bit is_last, input bit predict);
    result_t r;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk);
      frame_ch.valid <= 1'b0;
    end
    @(negedge clk);
    frame_ch.valid      <= 1'b1;
    frame_ch.pkt_byte   <= b;
    frame_ch.frame_last <= is_last;
    do @(posedge clk); while (frame_ch.ready !== 1'b1);
    if (classify_byte(b, is_last, r) && predict) pending_items.push_back(r);
  endtask

  task automatic send_frame(input frame_t f);
    byte_q_t bytes;
    result_t v;
    build_frame(f, bytes);
    // hand-typed verdicts take the place of the prediction
    if (f.typed) begin
      v.item_kind = KIND_VERDICT;
      v.name_byte = 8'd0;
      v.verdict   = f.want;
      v.key_len   = f.want_key;
      v.query_len = f.want_qlen;
      pending_items.push_back(v);
    end
    foreach (bytes[i]) put_byte(bytes[i], i == bytes.size() - 1, !f.typed);
  endtask

  // Hold the input until every result is out and the pipeline has emptied
  task automatic settle();
    @(negedge clk);
    frame_ch.valid <= 1'b0;
    while (pending_items.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_port(input logic [15:0] val);
    dns_port_we <= 1'b1;
    dns_port    <= val;
    port_cfg     = val;
    @(negedge clk);
    dns_port_we <= 1'b0;
  endtask

  // Directed frames: etype vihl proto dport ulen flags name end tail cut typed verdict key qlen
  frame_t directed_rows [24] = '{
    '{ETYPE_ARP,  8'h45, IP_PROTO_UDP, 16'd53, 16'd40, 8'h01, 3, 1, 4, 0, 1, V_PASS, 0, 0},
    '{ETYPE_IPV4, 8'h44, IP_PROTO_UDP, 16'd53, 16'd40, 8'h01, 3, 1, 4, 0, 1, V_DROP, 0, 0},
    '{ETYPE_IPV4, 8'h40, IP_PROTO_UDP, 16'd53, 16'd40, 8'h01, 3, 1, 4, 0, 1, V_DROP, 0, 0},
    '{ETYPE_IPV4, 8'h45, IP_PROTO_UDP, 16'd53, 16'd40, 8'h01, 3, 1, 4, 5, 1, V_DROP, 0, 0},
    '{ETYPE_IPV4, 8'h45, IP_PROTO_UDP, 16'd53, 16'd40, 8'h01, 3, 1, 4, 1, 1, V_DROP, 0, 0},
    '{ETYPE_IPV4, 8'h45, PROTO_TCP,    16'd53, 16'd40, 8'h01, 3, 1, 4, 0, 1, V_PASS, 0, 0},
    '{ETYPE_IPV6, 8'h45, PROTO_ICMP6,  16'd53, 16'd40, 8'h01, 3, 1, 4, 0, 1, V_PASS, 0, 0},
    '{ETYPE_IPV4, 8'h45, IP_PROTO_UDP, 16'd1234, 16'd7, 8'h01, 3, 1, 4, 0, 1, V_DROP, 0, 0},
    '{ETYPE_IPV4, 8'h45, IP_PROTO_UDP, 16'd54, 16'd40, 8'h01, 3, 1, 4, 0, 1, V_PASS, 0, 0},
    '{ETYPE_IPV4, 8'h45, IP_PROTO_UDP, 16'd53, 16'd40, 8'h80, 3, 1, 4, 0, 1, V_PASS, 0, 0},
    '{ETYPE_IPV4, 8'h45, IP_PROTO_UDP, 16'd53, 16'd40, 8'h78, 3, 1, 4, 0, 1, V_PASS, 0, 0},
    '{ETYPE_IPV4, 8'h45, IP_PROTO_UDP, 16'd53, 16'd40, 8'h01, 3, 1, 4, 46, 1, V_DROP, 0, 0},
    '{ETYPE_IPV4, 8'h45, IP_PROTO_UDP, 16'd53, 16'd40, 8'h01, 0, 1, 4, 0, 1, V_QUERY, 1, 5},
    '{ETYPE_IPV4, 8'h45, IP_PROTO_UDP, 16'd53, 16'd40, 8'h01, 0, 1, 0, 0, 1, V_QUERY, 0, 5},
    '{ETYPE_IPV6, 8'h45, IP_PROTO_UDP, 16'd53, 16'd40, 8'h01, 0, 1, 3, 0, 1, V_QUERY, 0, 5},
    '{ETYPE_IPV4, 8'h45, IP_PROTO_UDP, 16'd53, 16'hFFFF, 8'h07, 5, 1, 4, 0, 0, V_DROP, 0, 0},
    '{ETYPE_IPV6, 8'h45, IP_PROTO_UDP, 16'd53, 16'd40, 8'h01, 10, 1, 4, 0, 0, V_DROP, 0, 0},
    '{ETYPE_IPV4, 8'h4F, IP_PROTO_UDP, 16'd53, 16'd40, 8'h01, 3, 1, 6, 0, 0, V_DROP, 0, 0},
    '{ETYPE_IPV4, 8'h45, IP_PROTO_UDP, 16'd53, 16'd40, 8'h01, 4, 1, 2, 0, 0, V_DROP, 0, 0},
    '{ETYPE_IPV4, 8'h45, IP_PROTO_UDP, 16'd53, 16'd40, 8'h01, 4, 1, 0, 0, 0, V_DROP, 0, 0},
    '{ETYPE_IPV4, 8'h45, IP_PROTO_UDP, 16'd53, 16'd40, 8'h01, 6, 0, 0, 0, 0, V_DROP, 0, 0},
    '{ETYPE_IPV4, 8'h45, IP_PROTO_UDP, 16'd53, 16'd40, 8'h01, 255, 1, 4, 0, 0, V_DROP, 0, 0},
    '{ETYPE_IPV6, 8'h45, IP_PROTO_UDP, 16'd53, 16'd40, 8'h01, 300, 1, 4, 0, 0, V_DROP, 0, 0},
    '{ETYPE_IPV4, 8'hF5, IP_PROTO_UDP, 16'd53, 16'd8, 8'h01, 8, 1, 4, 0, 0, V_DROP, 0, 0}
  };

  // Port settings for the random sets; the first set runs on the reset value
  logic [15:0] port_sets [5];

  // Result consumer: random backpressure, none while steady
  always @(negedge clk) begin
    result_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Compare each result transfer against the oldest prediction
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      got.item_kind = kind_e'(result_ch.item_kind);
      got.name_byte = result_ch.name_byte;
      got.verdict   = verdict_e'(result_ch.verdict);
      got.key_len   = result_ch.key_len;
      got.query_len = result_ch.query_len;
      if (pending_items.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result kind=%0d byte=%02h verdict=%0d key=%0d qlen=%0d",
                   $time, got.item_kind, got.name_byte, got.verdict, got.key_len,
                   got.query_len);
      end else begin
        want = pending_items.pop_front();
        if (got.item_kind !== want.item_kind || got.name_byte !== want.name_byte ||
            got.verdict !== want.verdict || got.key_len !== want.key_len ||
            got.query_len !== want.query_len) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"%0t: mismatch expected kind=%0d byte=%02h verdict=%0d key=%0d ",
                      "qlen=%0d, actual kind=%0d byte=%02h verdict=%0d key=%0d qlen=%0d"},
                     $time, want.item_kind, want.name_byte, want.verdict, want.key_len,
                     want.query_len, got.item_kind, got.name_byte, got.verdict,
                     got.key_len, got.query_len);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((frame_ch.valid === 1'b1 && frame_ch.ready === 1'b1) ||
        (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
      $display("FAILED: results differ");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_n               = 1'b0;
    dns_port_we         = 1'b0;
    dns_port            = '0;
    frame_ch.valid      = 1'b0;
    frame_ch.pkt_byte   = '0;
    frame_ch.frame_last = 1'b0;
    result_ch.ready     = 1'b0;
    port_cfg            = DNS_PORT_RESET;
    port_sets           = '{DNS_PORT_RESET, 16'h0000, 16'hFFFF, 16'($urandom), 16'd5353};
    start_frame();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) send_frame(directed_rows[i]);

    // Random sets, each on its own port; the third runs without any idling
    foreach (port_sets[s]) begin
      if (s > 0) begin
        settle();
        write_port(port_sets[s]);
      end
      steady = (s == 2);
      repeat (FRAMES_PER_SET) send_frame(random_frame());
    end
    steady = 1'b0;

    settle();
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
